/* rtl/core/slh_pkg.sv */
// ----------------------------------------------------------------------------
// slh_pkg
// Shared types and constants of the stage latency histogram.
// ----------------------------------------------------------------------------
package slh_pkg;

	localparam int NUM_MARKERS = 8;
	localparam int NUM_BINS    = 64;

	localparam int MARK_AW = $clog2(NUM_MARKERS);
	localparam int BIN_AW  = $clog2(NUM_BINS);
	localparam int CNT_AW  = MARK_AW + BIN_AW;

	localparam int TS_W    = 32;
	localparam int TOTAL_W = 31;
	localparam int COUNT_W = 32;
	localparam int BW_W    = 16;
	localparam int BU_W    = 7;
	localparam int CFG_W   = 16;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX      = '1;
	localparam logic [BW_W-1:0]    BIN_WIDTH_RST  = BW_W'(1);
	localparam logic [BU_W-1:0]    BINS_IN_USE_RST = BU_W'(NUM_BINS);

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic {
		CFG_BIN_WIDTH   = 1'b0,
		CFG_BINS_IN_USE = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RDP,
		S_RDK,
		S_CAPK,
		S_DIVS,
		S_DIVW,
		S_RDB,
		S_WR,
		S_CLR
	} state_t;

	typedef struct packed {
		logic [TS_W-1:0]    mark;
		logic [TOTAL_W-1:0] acc;
	} mk_entry_t;

	localparam int MK_W = $bits(mk_entry_t);

endpackage

/* rtl/core/slh_ram.sv */
// ----------------------------------------------------------------------------
// slh_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module slh_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/slh_div.sv */
// ----------------------------------------------------------------------------
// slh_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slh_div
	import slh_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [TS_W-1:0] dividend,
	input  logic [BW_W-1:0] divisor,
	output logic            done,
	output logic [TS_W-1:0] quotient
);

	localparam int CW = $clog2(TS_W);

	logic [TS_W-1:0] quo_q;
	logic [BW_W-1:0] rem_q;
	logic [BW_W-1:0] dsr_q;
	logic [CW-1:0]   cnt_q;
	logic            act_q;
	logic            done_q;
	logic [BW_W:0]   trial;
	logic            fits;
	logic [BW_W:0]   diff;

	// The remainder stays below the divisor, so the shifted trial fits in BW_W+1 bits.
	assign trial = {rem_q, quo_q[TS_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (act_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(TS_W - 1)) begin
					act_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (act_q) begin
			quo_q <= {quo_q[TS_W-2:0], fits};
			rem_q <= fits ? diff[BW_W-1:0] : trial[BW_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/stage_latency_histogram.sv */
// ----------------------------------------------------------------------------
// stage_latency_histogram
// Multi-marker latency profiler with per-marker histograms held in RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// config    in         cfg_we                   cfg_addr, cfg_wdata
// command   in         start && !busy           mode, marker_index, timestamp, bin_index
// result    out        done (one cycle)         bin_count, total_time, first_mark, running
//
// Start and stop give their result in the cycle after the item is taken.
// A read, or a tick while disabled, passes through S_RDK and S_CAPK; a tick on a set
// marker adds S_RDP, the bit-serial divider and a RAM read-modify-write of its bin.
// A first tick clears the bin row of its marker, one bin at a time.
// Reset clears control state only; per-marker valid bits stand in for RAM contents.
// One item at a time; busy holds until a read or tick result; the receiver cannot stall.
// ----------------------------------------------------------------------------
module stage_latency_histogram
	import slh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [MARK_AW-1:0] marker_index,
	input  logic [TS_W-1:0]    timestamp,
	input  logic [BIN_AW-1:0]  bin_index,
	output logic               done,
	output logic [COUNT_W-1:0] bin_count,
	output logic [TOTAL_W-1:0] total_time,
	output logic               first_mark,
	output logic               running
);

	state_t state_q, state_d;

	logic [BW_W-1:0]        bin_width_q;
	logic [BU_W-1:0]        bins_in_use_q;
	logic                   running_q;
	logic [NUM_MARKERS-1:0] mark_set_q;
	logic [NUM_MARKERS-1:0] row_valid_q;

	mode_t              mode_q;
	logic [MARK_AW-1:0] k_q;
	logic [TS_W-1:0]    now_q;
	logic [BIN_AW-1:0]  bi_q;
	logic [TS_W-1:0]    prev_mark_q;
	logic [TOTAL_W-1:0] acc_q;
	logic [TS_W-1:0]    delta_q;
	logic [BIN_AW-1:0]  bin_q;
	logic [BIN_AW-1:0]  clr_q;

	logic               done_q;
	logic [COUNT_W-1:0] res_count_q;
	logic [TOTAL_W-1:0] res_total_q;
	logic               res_first_q;
	logic               res_running_q;

	logic               accept;
	logic [MARK_AW-1:0] prev_idx;
	logic               clr_last;

	logic              mk_we, mk_re;
	logic [MARK_AW-1:0] mk_waddr, mk_raddr;
	mk_entry_t         mk_wr, mk_rd;
	logic [MK_W-1:0]   mk_rdata;

	logic               cnt_we, cnt_re;
	logic [CNT_AW-1:0]  cnt_waddr, cnt_raddr;
	logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

	logic            div_start, div_done;
	logic [TS_W-1:0] div_quot;
	logic [BW_W-1:0] width_eff;
	logic [BU_W-1:0] used_eff;
	logic [BIN_AW-1:0] bin_sel;

	logic [TS_W-1:0]    diff;
	logic [TS_W-1:0]    sum;
	logic [TOTAL_W-1:0] sum_sat;
	logic [COUNT_W-1:0] cnt_inc;

	assign accept   = start && (state_q == S_IDLE);
	assign prev_idx = (k_q == '0) ? '0 : k_q - 1'b1;
	assign clr_last = clr_q == BIN_AW'(NUM_BINS - 1);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q   <= BIN_WIDTH_RST;
			bins_in_use_q <= BINS_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_BIN_WIDTH:   bin_width_q   <= cfg_wdata[BW_W-1:0];
				CFG_BINS_IN_USE: bins_in_use_q <= cfg_wdata[BU_W-1:0];
				default:         bin_width_q   <= bin_width_q;
			endcase
		end
	end

	always_comb begin
		width_eff = (bin_width_q == '0) ? BW_W'(1) : bin_width_q;
		if (bins_in_use_q == '0) begin
			used_eff = BU_W'(1);
		end else if (bins_in_use_q > BU_W'(NUM_BINS)) begin
			used_eff = BU_W'(NUM_BINS);
		end else begin
			used_eff = bins_in_use_q;
		end
		if (div_quot >= TS_W'(used_eff)) begin
			bin_sel = BIN_AW'(used_eff - 1'b1);
		end else begin
			bin_sel = div_quot[BIN_AW-1:0];
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (mode_t'(mode))
						MODE_TICK: begin
							if (!running_q) begin
								state_d = S_RDK;
							end else if (!mark_set_q[marker_index]) begin
								state_d = S_CLR;
							end else begin
								state_d = S_RDP;
							end
						end
						MODE_READ: state_d = S_RDK;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_RDP:  state_d = S_RDK;
			S_RDK:  state_d = S_CAPK;
			S_CAPK: state_d = (mode_q == MODE_TICK && running_q) ? S_DIVS : S_IDLE;
			S_DIVS: state_d = S_DIVW;
			S_DIVW: begin
				if (div_done) begin
					state_d = S_RDB;
				end
			end
			S_RDB:  state_d = S_WR;
			S_WR:   state_d = S_IDLE;
			S_CLR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Profiler control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			mark_set_q  <= '0;
			row_valid_q <= '0;
			clr_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept && (mode_t'(mode) == MODE_START || mode_t'(mode) == MODE_STOP)) begin
				running_q  <= mode_t'(mode) == MODE_START;
				mark_set_q <= '0;
				done_q     <= 1'b1;
			end
			if (accept) begin
				clr_q <= '0;
			end else if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
				if (clr_last) begin
					mark_set_q[k_q]  <= 1'b1;
					row_valid_q[k_q] <= 1'b1;
					done_q           <= 1'b1;
				end
			end
			if (state_q == S_CAPK && !(mode_q == MODE_TICK && running_q)) begin
				done_q <= 1'b1;
			end
			if (state_q == S_WR) begin
				done_q <= 1'b1;
			end
		end
	end

	always_comb begin
		diff    = now_q - prev_mark_q;
		sum     = {1'b0, acc_q} + {1'b0, delta_q[TOTAL_W-1:0]};
		sum_sat = sum[TS_W-1] ? TOTAL_MAX : sum[TOTAL_W-1:0];
		cnt_inc = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
	end

	// Item payload and working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			k_q    <= marker_index;
			now_q  <= timestamp;
			bi_q   <= bin_index;
		end
		if (state_q == S_RDK) begin
			// A marker that is not set reads as all ones.
			prev_mark_q <= mark_set_q[prev_idx] ? mk_rd.mark : '1;
		end
		if (state_q == S_CAPK) begin
			acc_q   <= row_valid_q[k_q] ? mk_rd.acc : '0;
			delta_q <= diff[TS_W-1] ? '0 : diff;
		end
		if (state_q == S_DIVW && div_done) begin
			bin_q <= bin_sel;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_count_q   <= '0;
			res_total_q   <= '0;
			res_first_q   <= 1'b0;
			res_running_q <= mode_t'(mode) == MODE_START;
		end else if (state_q == S_CAPK) begin
			res_count_q   <= (mode_q == MODE_READ && row_valid_q[k_q]) ? cnt_rdata : '0;
			res_total_q   <= row_valid_q[k_q] ? mk_rd.acc : '0;
			res_first_q   <= 1'b0;
			res_running_q <= running_q;
		end else if (state_q == S_WR) begin
			res_count_q   <= '0;
			res_total_q   <= sum_sat;
			res_first_q   <= 1'b0;
			res_running_q <= 1'b1;
		end else if (state_q == S_CLR && clr_last) begin
			res_count_q   <= '0;
			res_total_q   <= '0;
			res_first_q   <= 1'b1;
			res_running_q <= 1'b1;
		end
	end

	// Marker RAM: last mark and accumulated time per marker.
	always_comb begin
		mk_re    = state_q == S_RDP || state_q == S_RDK;
		mk_raddr = (state_q == S_RDP) ? prev_idx : k_q;
		mk_we    = (state_q == S_CLR && clr_q == '0) || state_q == S_WR;
		mk_waddr = k_q;
		mk_wr.mark = now_q;
		mk_wr.acc  = (state_q == S_WR) ? sum_sat : '0;
	end

	assign mk_rd = mk_entry_t'(mk_rdata);

	slh_ram #(
		.DEPTH (NUM_MARKERS),
		.WIDTH (MK_W)
	) u_mk_ram (
		.clk   (clk),
		.we    (mk_we),
		.waddr (mk_waddr),
		.wdata (mk_wr),
		.re    (mk_re),
		.raddr (mk_raddr),
		.rdata (mk_rdata)
	);

	// Bin count RAM, one row of bins per marker.
	always_comb begin
		cnt_re    = state_q == S_RDK || state_q == S_RDB;
		cnt_raddr = (state_q == S_RDB) ? {k_q, bin_q} : {k_q, bi_q};
		cnt_we    = state_q == S_CLR || state_q == S_WR;
		cnt_waddr = (state_q == S_CLR) ? {k_q, clr_q} : {k_q, bin_q};
		cnt_wdata = (state_q == S_CLR) ? '0 : cnt_inc;
	end

	slh_ram #(
		.DEPTH (NUM_MARKERS * NUM_BINS),
		.WIDTH (COUNT_W)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	assign div_start = state_q == S_DIVS;

	slh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (delta_q),
		.divisor  (width_eff),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign bin_count  = res_count_q;
	assign total_time = res_total_q;
	assign first_mark = res_first_q;
	assign running    = res_running_q;

endmodule

/* rtl/core/slh_checker.sv */
// ----------------------------------------------------------------------------
// slh_checker
// Port-level checks of the stage latency histogram, bound to the top level.
// ----------------------------------------------------------------------------
module slh_checker
	import slh_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         mode,
	input logic               done,
	input logic [COUNT_W-1:0] bin_count,
	input logic [TOTAL_W-1:0] total_time,
	input logic               first_mark,
	input logic               running
);

	// Every taken item either keeps the block busy or reports at once.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("item taken but block neither busy nor done");

	// The result always shows the block ready for the next item.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result given while still busy");

	// A first mark only happens while the profiler runs, and starts a clean total.
	a_first_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && first_mark |-> running && total_time == '0 && bin_count == '0)
		else $error("first mark with stale data or while stopped");

	// A start item always leaves the profiler running.
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_START |=> done && running)
		else $error("start item did not enable the profiler");

endmodule

bind stage_latency_histogram slh_checker u_slh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.mode       (mode),
	.done       (done),
	.bin_count  (bin_count),
	.total_time (total_time),
	.first_mark (first_mark),
	.running    (running)
);

/* dv/stage_latency_histogram_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stage_latency_histogram_checker
// Watches the configuration, command and result ports of the latency profiler.
// It keeps its own copy of the marks, totals and bin counts, works out the
// result of every accepted command, and compares each result in arrival order.
// ----------------------------------------------------------------------------
module stage_latency_histogram_checker
	import slh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         mode,
	input  logic [MARK_AW-1:0] marker_index,
	input  logic [TS_W-1:0]    timestamp,
	input  logic [BIN_AW-1:0]  bin_index,
	input  logic               done,
	input  logic [COUNT_W-1:0] bin_count,
	input  logic [TOTAL_W-1:0] total_time,
	input  logic               first_mark,
	input  logic               running,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [TOTAL_W-1:0] total;
		logic               first;
		logic               run;
	} profile_result_t;

	logic [BW_W-1:0]    width_cfg;
	logic [BU_W-1:0]    used_cfg;
	logic               enabled;
	logic [TS_W-1:0]    marker_mark [NUM_MARKERS];
	logic               marker_set [NUM_MARKERS];
	logic [TOTAL_W-1:0] marker_total [NUM_MARKERS];
	logic [COUNT_W-1:0] bin_tally [NUM_MARKERS][NUM_BINS];

	profile_result_t expected_results[$];
	int reported = 0;

	function automatic void clear_marks();
		for (int m = 0; m < NUM_MARKERS; m++) begin
			marker_mark[m] = '1;
			marker_set[m]  = 1'b0;
		end
	endfunction

	// Computes the result of one command and updates the profiler copy.
	function automatic profile_result_t profile_command(mode_t op, int k, logic [TS_W-1:0] ts,
			int bi);
		profile_result_t res;
		logic [TS_W-1:0] delta;
		logic [32:0]     sum;
		int unsigned     eff_width;
		int unsigned     eff_used;
		int unsigned     bin;
		int              prev;
		res = '0;
		case (op)
			MODE_TICK: begin
				if (enabled) begin
					if (!marker_set[k]) begin
						marker_mark[k]  = ts;
						marker_set[k]   = 1'b1;
						marker_total[k] = '0;
						for (int b = 0; b < NUM_BINS; b++)
							bin_tally[k][b] = '0;
						res.first = 1'b1;
					end else begin
						prev  = (k == 0) ? 0 : k - 1;
						delta = ts - marker_mark[prev];
						if (delta[TS_W-1])
							delta = '0;
						marker_mark[k] = ts;
						eff_width = (width_cfg == 0) ? 1 : width_cfg;
						eff_used  = (used_cfg == 0) ? 1 : (used_cfg > NUM_BINS) ? NUM_BINS : used_cfg;
						bin = delta / eff_width;
						if (bin >= eff_used)
							bin = eff_used - 1;
						if (bin_tally[k][bin] != '1)
							bin_tally[k][bin]++;
						sum = {2'b00, marker_total[k]} + {1'b0, delta};
						if (sum > {2'b00, TOTAL_MAX})
							sum = {2'b00, TOTAL_MAX};
						marker_total[k] = sum[TOTAL_W-1:0];
					end
				end
				res.total = marker_total[k];
			end
			MODE_START: begin
				clear_marks();
				enabled = 1'b1;
			end
			MODE_STOP: begin
				enabled = 1'b0;
				clear_marks();
			end
			default: begin
				res.total = marker_total[k];
				res.count = bin_tally[k][bi];
			end
		endcase
		res.run = enabled;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		profile_result_t want;
		profile_result_t got;
		if (!arst_n) begin
			width_cfg = BIN_WIDTH_RST;
			used_cfg  = BINS_IN_USE_RST;
			enabled   = 1'b0;
			clear_marks();
			for (int m = 0; m < NUM_MARKERS; m++) begin
				marker_total[m] = '0;
				for (int b = 0; b < NUM_BINS; b++)
					bin_tally[m][b] = '0;
			end
			expected_results.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx_t'(cfg_addr) == CFG_BIN_WIDTH)
					width_cfg = cfg_wdata[BW_W-1:0];
				else
					used_cfg = cfg_wdata[BU_W-1:0];
			end
			// The result of the previous command is retired before a new one is queued.
			if (done) begin
				got = '{bin_count, total_time, first_mark, running};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (reported < 10) begin
						reported++;
						$display("%0t: unexpected result count=%h total=%h first=%b run=%b",
							$realtime, got.count, got.total, got.first, got.run);
					end
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (got !== want) begin
						fail_count++;
						if (reported < 10) begin
							reported++;
							$display("%0t: result mismatch, expected count=%h total=%h first=%b run=%b",
								$realtime, want.count, want.total, want.first, want.run);
							$display("%0t:                  actual count=%h total=%h first=%b run=%b",
								$realtime, got.count, got.total, got.first, got.run);
						end
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(profile_command(mode_t'(mode), int'(marker_index),
					timestamp, int'(bin_index)));
			pending = expected_results.size();
		end
	end

endmodule

/* dv/stage_latency_histogram_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stage_latency_histogram_test
// Drives commands into the latency profiler: a directed opening that covers
// first marks, wrapped and negative deltas, saturating totals and disabled
// ticks, then random runs of ordered ticks and reads under several bin setups
// and sender gap rates. Results are checked by the checker module.
// ----------------------------------------------------------------------------
module stage_latency_histogram_test;
	import slh_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_addr = 1'b0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         mode = MODE_TICK;
	logic [MARK_AW-1:0] marker_index = '0;
	logic [TS_W-1:0]    timestamp = '0;
	logic [BIN_AW-1:0]  bin_index = '0;
	logic               done;
	logic [COUNT_W-1:0] bin_count;
	logic [TOTAL_W-1:0] total_time;
	logic               first_mark;
	logic               running;

	int fail_count;
	int pending;
	int checked;

	int sender_idle_pct = 0;
	int commands_sent = 0;
	int ticks_sent = 0;
	int reads_sent = 0;
	int setups_used = 0;

	stage_latency_histogram u_dut (.*);

	stage_latency_histogram_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with start still high.
	task automatic issue(mode_t op, int k, logic [TS_W-1:0] ts, int bi);
		while ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start        = 1'b1;
		mode         = op;
		marker_index = MARK_AW'(k);
		timestamp    = ts;
		bin_index    = BIN_AW'(bi);
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		commands_sent++;
		if (op == MODE_TICK)
			ticks_sent++;
		if (op == MODE_READ)
			reads_sent++;
	endtask

	task automatic write_setup(logic [BW_W-1:0] width, logic [BU_W-1:0] used);
		start = 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = CFG_BIN_WIDTH;
		cfg_wdata = width;
		@(negedge clk);
		cfg_addr  = CFG_BINS_IN_USE;
		cfg_wdata = CFG_W'(used);
		@(negedge clk);
		cfg_we = 1'b0;
		setups_used++;
	endtask

	initial begin
		logic [BW_W-1:0] width_list [6];
		logic [BU_W-1:0] used_list [6];
		logic [TS_W-1:0] now_ms;
		logic [TS_W-1:0] ts;
		int unsigned     eff_used;
		int unsigned     span;
		int              cursor;
		int              k;
		int              r;
		int              q;

		width_list = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd250, 16'd40000};
		used_list  = '{7'd1, 7'd127, 7'd64, 7'd0, 7'd10, 7'd33};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: bin width 1, all 64 bins.
		issue(MODE_READ, 0, '0, 0);
		issue(MODE_TICK, 0, 32'd5, 0);
		issue(MODE_START, 0, '0, 0);
		issue(MODE_TICK, 0, 32'd100, 0);
		issue(MODE_TICK, 0, 32'd130, 0);
		// Largest positive delta lands in the last bin and saturates the total.
		issue(MODE_TICK, 0, 32'h8000_0081, 0);
		issue(MODE_TICK, 0, 32'h8000_0000, 0);
		issue(MODE_TICK, 1, 32'hFFFF_FFFF, 0);
		issue(MODE_TICK, 1, 32'h0000_0010, 0);
		// Marker 2 was never set, so marker 3 measures from all ones.
		issue(MODE_TICK, 3, 32'hFFFF_FFFF, 0);
		issue(MODE_TICK, 3, 32'hFFFF_FFFF, 0);
		issue(MODE_TICK, 3, 32'd20, 0);
		issue(MODE_READ, 0, '0, 63);
		issue(MODE_READ, 0, '1, 30);
		issue(MODE_READ, 3, '0, 0);
		issue(MODE_READ, 7, '0, 63);
		issue(MODE_STOP, 0, '0, 0);
		issue(MODE_TICK, 0, 32'd500, 0);
		issue(MODE_READ, 0, '0, 63);
		issue(MODE_START, 5, '1, 21);
		issue(MODE_TICK, 0, 32'd1, 0);
		issue(MODE_READ, 0, '0, 63);
		issue(MODE_TICK, 7, 32'hAAAA_AAAA, 0);
		issue(MODE_TICK, 7, 32'h5555_5555, 0);
		issue(MODE_READ, 7, '0, 0);

		for (int seg = 0; seg < 6; seg++) begin
			write_setup(width_list[seg], used_list[seg]);
			sender_idle_pct = (seg < 2) ? 21 : (seg < 4) ? 45 : 0;
			eff_used = (used_list[seg] == 0) ? 1 : (used_list[seg] > NUM_BINS) ? NUM_BINS :
				used_list[seg];
			span = ((width_list[seg] == 0) ? 1 : width_list[seg]) * eff_used * 5 / 4 + 1;
			now_ms = $urandom;
			cursor = 0;
			issue(MODE_START, $urandom_range(7), $urandom, $urandom_range(63));
			for (int n = 0; n < 249; n++) begin
				r = $urandom_range(99);
				if (r < 3) begin
					now_ms = $urandom;
					cursor = 0;
					issue(MODE_START, $urandom_range(7), $urandom, $urandom_range(63));
				end else if (r < 5) begin
					issue(MODE_STOP, $urandom_range(7), $urandom, $urandom_range(63));
				end else if (r < 65) begin
					// Mostly ticks in marker order with growing time, so deltas
					// measure the gap from the marker before.
					k = ($urandom_range(4) == 0) ? $urandom_range(7) : cursor;
					cursor = (k + 1) % NUM_MARKERS;
					q = $urandom_range(19);
					if (q == 0) begin
						ts = $urandom;
					end else if (q == 1) begin
						ts = now_ms - $urandom_range(span);
					end else begin
						now_ms = now_ms + $urandom_range(span);
						ts = now_ms;
					end
					issue(MODE_TICK, k, ts, $urandom_range(63));
				end else begin
					issue(MODE_READ, $urandom_range(7), $urandom,
						($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(eff_used - 1));
				end
			end
		end

		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);

		$display("Sent %0d commands (%0d ticks, %0d reads) over %0d bin setups besides reset.",
			commands_sent, ticks_sent, reads_sent, setups_used);
		$display("Checked %0d results; %0d failures.", checked, fail_count);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
